### src/spq_pkg.sv
package spq_pkg;

    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;
    localparam int FILL_W     = 5;
    localparam int CAPACITY_D = 16;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } spq_op_t;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic                    push_en;
        logic                    pop_en;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } spq_ctrl_t;

endpackage

### src/spq_cell.sv
module spq_cell
    import spq_pkg::*;
(
    input  logic                    aclk,
    input  spq_ctrl_t               ctrl,
    input  logic                    occupied,
    input  logic                    left_ge,
    input  logic signed [KEY_W-1:0] left_key,
    input  logic signed [VAL_W-1:0] left_value,
    input  logic signed [KEY_W-1:0] right_key,
    input  logic signed [VAL_W-1:0] right_value,
    output logic signed [KEY_W-1:0] cell_key,
    output logic signed [VAL_W-1:0] cell_value,
    output logic                    cell_ge
);

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] value_next;

    // An empty cell counts as holding a key at least as large as any pushed key.
    assign cell_ge    = !occupied || (key_reg >= ctrl.key);
    assign cell_key   = key_reg;
    assign cell_value = value_reg;

    always_comb begin
        key_next   = key_reg;
        value_next = value_reg;
        if (ctrl.push_en) begin
            if (cell_ge && left_ge) begin
                key_next   = left_key;
                value_next = left_value;
            end else if (cell_ge) begin
                key_next   = ctrl.key;
                value_next = ctrl.value;
            end
        end else if (ctrl.pop_en) begin
            key_next   = right_key;
            value_next = right_value;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule

### src/sorted_priority_queue_unit.sv
// The result is registered: it shows on m_valid in the cycle after the input is accepted.
// Throughput: one push or pop per cycle while s_ready holds; every cell of the
// chain compares against the broadcast key and shifts with its neighbor in the same cycle.
// Reset: synchronous, active low; it empties the queue and clears the result valid.
// Stored keys and values are not reset; only slots below the entry count are read.
module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_D
)
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_operation,
    input  logic signed [KEY_W-1:0] s_prio_key,
    input  logic signed [VAL_W-1:0] s_item_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [VAL_W-1:0] m_popped_value,
    output logic                    m_was_empty,
    output logic                    m_was_full,
    output logic [FILL_W-1:0]       m_fill_level
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic signed [VAL_W-1:0] m_popped_value_reg;
    logic signed [VAL_W-1:0] m_popped_value_next;
    logic                    m_was_empty_reg;
    logic                    m_was_empty_next;
    logic                    m_was_full_reg;
    logic                    m_was_full_next;
    logic [FILL_W-1:0]       m_fill_level_reg;
    logic [FILL_W-1:0]       m_fill_level_next;

    logic                    accept;
    logic                    is_full;
    logic                    is_empty;
    spq_ctrl_t               ctrl;

    logic                    occ      [CAPACITY];
    logic                    ge       [CAPACITY];
    logic signed [KEY_W-1:0] keys     [CAPACITY];
    logic signed [VAL_W-1:0] values   [CAPACITY];

    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    assign ctrl.push_en = accept && (spq_op_t'(s_operation) == OP_PUSH) && !is_full;
    assign ctrl.pop_en  = accept && (spq_op_t'(s_operation) == OP_POP) && !is_empty;
    assign ctrl.key     = s_prio_key;
    assign ctrl.value   = s_item_value;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            assign occ[g] = (count_reg > CNT_W'(g));
            if (g == 0) begin : g_head
                spq_cell u_cell (
                    .aclk        (aclk),
                    .ctrl        (ctrl),
                    .occupied    (occ[g]),
                    .left_ge     (1'b0),
                    .left_key    (s_prio_key),
                    .left_value  (s_item_value),
                    .right_key   (keys[g+1]),
                    .right_value (values[g+1]),
                    .cell_key    (keys[g]),
                    .cell_value  (values[g]),
                    .cell_ge     (ge[g])
                );
            end else if (g == CAPACITY - 1) begin : g_tail
                // The tail cell empties on a pop, so it may keep its contents.
                spq_cell u_cell (
                    .aclk        (aclk),
                    .ctrl        (ctrl),
                    .occupied    (occ[g]),
                    .left_ge     (ge[g-1]),
                    .left_key    (keys[g-1]),
                    .left_value  (values[g-1]),
                    .right_key   (keys[g]),
                    .right_value (values[g]),
                    .cell_key    (keys[g]),
                    .cell_value  (values[g]),
                    .cell_ge     (ge[g])
                );
            end else begin : g_mid
                spq_cell u_cell (
                    .aclk        (aclk),
                    .ctrl        (ctrl),
                    .occupied    (occ[g]),
                    .left_ge     (ge[g-1]),
                    .left_key    (keys[g-1]),
                    .left_value  (values[g-1]),
                    .right_key   (keys[g+1]),
                    .right_value (values[g+1]),
                    .cell_key    (keys[g]),
                    .cell_value  (values[g]),
                    .cell_ge     (ge[g])
                );
            end
        end
    endgenerate

    always_comb begin
        count_next          = count_reg;
        m_valid_next        = m_valid_reg;
        m_popped_value_next = m_popped_value_reg;
        m_was_empty_next    = m_was_empty_reg;
        m_was_full_next     = m_was_full_reg;
        m_fill_level_next   = m_fill_level_reg;

        if (ctrl.push_en) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.pop_en) begin
            count_next = count_reg - CNT_W'(1);
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next        = 1'b1;
            m_popped_value_next = ctrl.pop_en ? values[0] : '0;
            m_was_empty_next    = (spq_op_t'(s_operation) == OP_POP) && is_empty;
            m_was_full_next     = (spq_op_t'(s_operation) == OP_PUSH) && is_full;
            m_fill_level_next   = FILL_W'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        m_popped_value_reg <= m_popped_value_next;
        m_was_empty_reg    <= m_was_empty_next;
        m_was_full_reg     <= m_was_full_next;
        m_fill_level_reg   <= m_fill_level_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_popped_value = m_popped_value_reg;
    assign m_was_empty    = m_was_empty_reg;
    assign m_was_full     = m_was_full_reg;
    assign m_fill_level   = m_fill_level_reg;

endmodule
